// ===== sv/gebs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gebs_pkg: shared types and constants of the grid elevation sampler
// Field widths, status and register codes, the item descriptor that travels
// from the front end to the back end, and the back-end state encoding.
// ----------------------------------------------------------------------------
package gebs_pkg;

    localparam int MAX_ROWS_DEF      = 256;
    localparam int MAX_COLS_DEF      = 256;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COORD_W   = 33;
    localparam int ELEV_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int SIZE_W    = 9;
    localparam int CELL_W    = 8;
    localparam int NUM_W     = COORD_W + SIZE_W;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_W    = ELEV_W + 1;
    localparam int RESULT_W  = ELEV_W + STATUS_W;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_BOX  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNWRITTEN   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 3'd4;

    localparam logic       OP_WRITE      = 1'b0;
    localparam logic       OP_QUERY      = 1'b1;
    localparam logic [1:0] MODE_NEAREST  = 2'd0;
    localparam logic [1:0] MODE_BILINEAR = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_LAT_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LON_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LON_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 3'd5;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_RESULT,
        KIND_NEAREST,
        KIND_BILINEAR
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic [STATUS_W-1:0]        status;
        logic [CELL_W-1:0]          row;
        logic [CELL_W-1:0]          col;
        logic signed [ELEV_W-1:0]   value;
        logic [COORD_W-1:0]         d_lat;
        logic [COORD_W-1:0]         d_lon;
        logic [COORD_W-1:0]         span_lat;
        logic [COORD_W-1:0]         span_lon;
        logic [SIZE_W-1:0]          nm1_lat;
        logic [SIZE_W-1:0]          nm1_lon;
    } desc_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_ADDR,
        S_READ,
        S_RWAIT,
        S_CHECK,
        S_BMUL0,
        S_BRND0,
        S_BMUL1,
        S_BRND1,
        S_PUSH
    } back_state_t;

endpackage
`default_nettype wire

// ===== sv/gebs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gebs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gebs_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 65536
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/gebs_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gebs_fifo: two-entry queue
// Decouples producer and consumer; full and empty come straight from a count.
// ----------------------------------------------------------------------------
module gebs_fifo #(
    parameter int WIDTH = 8
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  wdata,
    output logic             full,
    input  wire              pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// ===== sv/gebs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gebs_div: radix-2 grid coordinate divider
// Computes floor((num << FB) / span), one quotient bit per cycle; a zero span
// gives zero.
// ----------------------------------------------------------------------------
module gebs_div #(
    parameter int QB = 8,
    parameter int FB = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [gebs_pkg::NUM_W-1:0]    num,
    input  wire [gebs_pkg::COORD_W-1:0]  span,
    output logic [QB+FB-1:0]             quo,
    output logic                         busy
);

    localparam int K   = QB + FB;
    localparam int CW  = $clog2(K + 1);
    localparam int RW  = gebs_pkg::COORD_W;

    logic [RW-1:0]  rem_reg;
    logic [RW-1:0]  span_reg;
    logic [K-1:0]   sh_reg;
    logic [CW-1:0]  cnt_reg;
    logic [RW:0]    trial;
    logic           fits;

    assign busy  = (cnt_reg != '0);
    assign quo   = sh_reg;
    assign trial = {rem_reg, sh_reg[K-1]};
    assign fits  = (trial >= {1'b0, span_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= (span == '0) ? '0 : CW'(K);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            span_reg <= span;
            rem_reg  <= RW'(num >> QB);
            sh_reg   <= (span == '0) ? '0 : {num[QB-1:0], {FB{1'b0}}};
        end
        else if (busy)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_reg <= fits ? RW'(trial - {1'b0, span_reg}) : trial[RW-1:0];
            sh_reg  <= {sh_reg[K-2:0], fits};
        end
    end

endmodule
`default_nettype wire

// ===== sv/gebs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gebs_front: configuration registers and item classification
// Checks bounds, mode and cell index, and builds the descriptor for the back.
// ----------------------------------------------------------------------------
module gebs_front #(
    parameter int MAX_ROWS = gebs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gebs_pkg::MAX_COLS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire [gebs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [gebs_pkg::COORD_W-1:0]          cfg_data,
    input  wire                                  push,
    output logic                                 full,
    input  wire                                  operation,
    input  wire [1:0]                            mode,
    input  wire signed [gebs_pkg::COORD_W-1:0]   query_lat,
    input  wire signed [gebs_pkg::COORD_W-1:0]   query_lon,
    input  wire [gebs_pkg::CELL_W-1:0]           cell_col,
    input  wire [gebs_pkg::CELL_W-1:0]           cell_row,
    input  wire signed [gebs_pkg::ELEV_W-1:0]    write_value,
    input  wire                                  clearing,
    input  wire                                  desc_full,
    output logic                                 desc_push,
    output gebs_pkg::desc_t                      desc
);

    localparam int CW = gebs_pkg::COORD_W;
    localparam int SW = gebs_pkg::SIZE_W;

    logic signed [CW-1:0] lat_start_reg;
    logic signed [CW-1:0] lon_start_reg;
    logic signed [CW-1:0] lat_end_reg;
    logic signed [CW-1:0] lon_end_reg;
    logic [SW-1:0]        rows_used_reg;
    logic [SW-1:0]        cols_used_reg;

    logic [SW-1:0]        rows_n;
    logic [SW-1:0]        cols_n;
    logic signed [CW:0]   ds_lat, de_lat, sp_lat;
    logic signed [CW:0]   ds_lon, de_lon, sp_lon;
    logic                 in_lat, in_lon;
    logic                 bad_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_start_reg <= '0;
            lon_start_reg <= '0;
            lat_end_reg   <= '0;
            lon_end_reg   <= '0;
            rows_used_reg <= SW'(256);
            cols_used_reg <= SW'(256);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gebs_pkg::REG_LAT_START: lat_start_reg <= cfg_data;
                gebs_pkg::REG_LON_START: lon_start_reg <= cfg_data;
                gebs_pkg::REG_LAT_END:   lat_end_reg   <= cfg_data;
                gebs_pkg::REG_LON_END:   lon_end_reg   <= cfg_data;
                gebs_pkg::REG_ROWS_USED: rows_used_reg <= cfg_data[SW-1:0];
                gebs_pkg::REG_COLS_USED: cols_used_reg <= cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // saturate the grid size to [2, MAX]
    always_comb
    begin
        if (rows_used_reg < SW'(2))
            rows_n = SW'(2);
        else if (int'(rows_used_reg) > MAX_ROWS)
            rows_n = SW'(MAX_ROWS);
        else
            rows_n = rows_used_reg;

        if (cols_used_reg < SW'(2))
            cols_n = SW'(2);
        else if (int'(cols_used_reg) > MAX_COLS)
            cols_n = SW'(MAX_COLS);
        else
            cols_n = cols_used_reg;
    end

    assign ds_lat = (CW+1)'(query_lat) - (CW+1)'(lat_start_reg);
    assign de_lat = (CW+1)'(query_lat) - (CW+1)'(lat_end_reg);
    assign sp_lat = (CW+1)'(lat_end_reg) - (CW+1)'(lat_start_reg);
    assign ds_lon = (CW+1)'(query_lon) - (CW+1)'(lon_start_reg);
    assign de_lon = (CW+1)'(query_lon) - (CW+1)'(lon_end_reg);
    assign sp_lon = (CW+1)'(lon_end_reg) - (CW+1)'(lon_start_reg);

    // inside when the distances to both ends have opposite signs (or touch)
    assign in_lat = (!ds_lat[CW] && (de_lat[CW] || de_lat == '0)) ||
                    (!de_lat[CW] && (ds_lat[CW] || ds_lat == '0));
    assign in_lon = (!ds_lon[CW] && (de_lon[CW] || de_lon == '0)) ||
                    (!de_lon[CW] && (ds_lon[CW] || ds_lon == '0));

    assign bad_index = ({1'b0, cell_col} >= cols_n) || ({1'b0, cell_row} >= rows_n);

    assign full      = desc_full || clearing;
    assign desc_push = push && !full;

    always_comb
    begin
        desc.kind     = gebs_pkg::KIND_RESULT;
        desc.status   = gebs_pkg::ST_OK;
        desc.row      = cell_row;
        desc.col      = cell_col;
        desc.value    = write_value;
        desc.d_lat    = ds_lat[CW] ? CW'(-ds_lat) : ds_lat[CW-1:0];
        desc.d_lon    = ds_lon[CW] ? CW'(-ds_lon) : ds_lon[CW-1:0];
        desc.span_lat = sp_lat[CW] ? CW'(-sp_lat) : sp_lat[CW-1:0];
        desc.span_lon = sp_lon[CW] ? CW'(-sp_lon) : sp_lon[CW-1:0];
        desc.nm1_lat  = rows_n - SW'(1);
        desc.nm1_lon  = cols_n - SW'(1);
        if (operation == gebs_pkg::OP_WRITE)
        begin
            if (bad_index)
                desc.status = gebs_pkg::ST_BAD_INDEX;
            else
                desc.kind = gebs_pkg::KIND_WRITE;
        end
        else if (!in_lat || !in_lon)
        begin
            desc.status = gebs_pkg::ST_OUT_OF_BOX;
        end
        else
        begin
            unique case (mode)
                gebs_pkg::MODE_NEAREST:  desc.kind   = gebs_pkg::KIND_NEAREST;
                gebs_pkg::MODE_BILINEAR: desc.kind   = gebs_pkg::KIND_BILINEAR;
                default:                 desc.status = gebs_pkg::ST_UNSUPPORTED;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/gebs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gebs_back: item execution
// Clears the grid after reset, stores cells, maps queries to grid coordinates,
// reads the cells and blends them.
// ----------------------------------------------------------------------------
module gebs_back #(
    parameter int MAX_ROWS      = gebs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS      = gebs_pkg::MAX_COLS_DEF,
    parameter int FRACTION_BITS = gebs_pkg::FRACTION_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  desc_empty,
    input  gebs_pkg::desc_t                      desc_in,
    output logic                                 desc_pop,
    output logic                                 clearing,
    input  wire                                  res_full,
    output logic                                 res_push,
    output logic [gebs_pkg::RESULT_W-1:0]        res_data
);

    localparam int FB    = FRACTION_BITS;
    localparam int QBR   = $clog2(MAX_ROWS);
    localparam int QBC   = $clog2(MAX_COLS);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = gebs_pkg::ELEV_W;
    localparam int WW    = gebs_pkg::WORD_W;
    localparam int NW    = gebs_pkg::NUM_W;
    localparam int PW    = EW + FB + 2;
    localparam int XW    = EW + FB + 4;
    localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);

    gebs_pkg::back_state_t state_reg, state_next;
    gebs_pkg::desc_t       desc_reg;

    logic [AW-1:0]              clr_reg;
    logic [NW-1:0]              num_lat_reg, num_lon_reg;
    logic                       div_start;
    logic [QBR+FB-1:0]          quo_lat;
    logic [QBC+FB-1:0]          quo_lon;
    logic                       busy_lat, busy_lon;
    logic [QBR-1:0]             y0_reg, y1_reg;
    logic [QBC-1:0]             x0_reg, x1_reg;
    logic [1:0]                 rd_reg;
    logic                       cap_vld_reg;
    logic [1:0]                 cap_idx_reg;
    logic signed [EW-1:0]       cell_reg [4];
    logic                       marks_ok_reg;
    logic signed [PW-1:0]       p0_reg, p1_reg;
    logic signed [EW-1:0]       r0_reg, r1_reg;
    logic signed [EW-1:0]       elev_reg;
    logic [gebs_pkg::STATUS_W-1:0] status_reg;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [WW-1:0]              ram_wdata, ram_rdata;
    logic                       last_read;
    logic [FB-1:0]              fx, fy;

    assign fy = quo_lat[FB-1:0];
    assign fx = quo_lon[FB-1:0];
    assign last_read = (desc_reg.kind == gebs_pkg::KIND_NEAREST) || (rd_reg == 2'd3);

    // (a << FB) + p, rounded half up and shifted back
    function automatic logic signed [EW-1:0] round_blend(
        input logic signed [EW-1:0] a,
        input logic signed [PW-1:0] p
    );
        logic signed [XW-1:0] acc;
        acc = (XW'(a) <<< FB) + XW'(p) + (XW'(1) <<< (FB - 1));
        return acc[FB+EW-1:FB];
    endfunction

    // (b - a) * f
    function automatic logic signed [PW-1:0] blend_prod(
        input logic signed [EW-1:0] a,
        input logic signed [EW-1:0] b,
        input logic [FB-1:0]        f
    );
        logic signed [EW:0] diff;
        diff = (EW+1)'(b) - (EW+1)'(a);
        return PW'(diff) * PW'($signed({1'b0, f}));
    endfunction

    gebs_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gebs_div #(
        .QB (QBR),
        .FB (FB)
    ) u_div_lat (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_lat_reg),
        .span  (desc_reg.span_lat),
        .quo   (quo_lat),
        .busy  (busy_lat)
    );

    gebs_div #(
        .QB (QBC),
        .FB (FB)
    ) u_div_lon (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_lon_reg),
        .span  (desc_reg.span_lon),
        .quo   (quo_lon),
        .busy  (busy_lon)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gebs_pkg::S_CLEAR:
                if (clr_reg == AW'(DEPTH - 1)) state_next = gebs_pkg::S_IDLE;
            gebs_pkg::S_IDLE:
                if (!desc_empty)
                begin
                    if (desc_in.kind == gebs_pkg::KIND_NEAREST ||
                        desc_in.kind == gebs_pkg::KIND_BILINEAR)
                        state_next = gebs_pkg::S_MUL;
                    else
                        state_next = gebs_pkg::S_PUSH;
                end
            gebs_pkg::S_MUL:    state_next = gebs_pkg::S_DSTART;
            gebs_pkg::S_DSTART: state_next = gebs_pkg::S_DIV;
            gebs_pkg::S_DIV:
                if (!busy_lat && !busy_lon) state_next = gebs_pkg::S_ADDR;
            gebs_pkg::S_ADDR:   state_next = gebs_pkg::S_READ;
            gebs_pkg::S_READ:
                if (last_read) state_next = gebs_pkg::S_RWAIT;
            gebs_pkg::S_RWAIT:  state_next = gebs_pkg::S_CHECK;
            gebs_pkg::S_CHECK:
                if (marks_ok_reg && desc_reg.kind == gebs_pkg::KIND_BILINEAR)
                    state_next = gebs_pkg::S_BMUL0;
                else
                    state_next = gebs_pkg::S_PUSH;
            gebs_pkg::S_BMUL0:  state_next = gebs_pkg::S_BRND0;
            gebs_pkg::S_BRND0:  state_next = gebs_pkg::S_BMUL1;
            gebs_pkg::S_BMUL1:  state_next = gebs_pkg::S_BRND1;
            gebs_pkg::S_BRND1:  state_next = gebs_pkg::S_PUSH;
            gebs_pkg::S_PUSH:
                if (!res_full) state_next = gebs_pkg::S_IDLE;
            default:            state_next = gebs_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        clearing  = (state_reg == gebs_pkg::S_CLEAR);
        desc_pop  = (state_reg == gebs_pkg::S_IDLE) && !desc_empty;
        div_start = (state_reg == gebs_pkg::S_DSTART);
        res_push  = (state_reg == gebs_pkg::S_PUSH) && !res_full;
        res_data  = {status_reg, elev_reg};
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        ram_raddr = AW'(rd_reg[1] ? y1_reg : y0_reg) * COLS_A +
                    AW'(rd_reg[0] ? x1_reg : x0_reg);
        if (state_reg == gebs_pkg::S_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (desc_pop && desc_in.kind == gebs_pkg::KIND_WRITE)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(desc_in.row) * COLS_A + AW'(desc_in.col);
            ram_wdata = {1'b1, desc_in.value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gebs_pkg::S_CLEAR;
            clr_reg     <= '0;
            cap_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_vld_reg <= (state_reg == gebs_pkg::S_READ);
            if (state_reg == gebs_pkg::S_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cap_idx_reg <= rd_reg;
        if (cap_vld_reg)
        begin
            cell_reg[cap_idx_reg] <= ram_rdata[EW-1:0];
            marks_ok_reg          <= marks_ok_reg && ram_rdata[EW];
        end
        case (state_reg)
            gebs_pkg::S_IDLE:
                if (!desc_empty)
                begin
                    desc_reg   <= desc_in;
                    status_reg <= desc_in.status;
                    elev_reg   <= '0;
                end
            gebs_pkg::S_MUL:
            begin
                num_lat_reg <= NW'(desc_reg.d_lat) * NW'(desc_reg.nm1_lat);
                num_lon_reg <= NW'(desc_reg.d_lon) * NW'(desc_reg.nm1_lon);
            end
            gebs_pkg::S_ADDR:
            begin
                // nearest rounds up at one half; bilinear takes floor and ceil
                if (desc_reg.kind == gebs_pkg::KIND_NEAREST)
                begin
                    y0_reg <= quo_lat[QBR+FB-1:FB] + QBR'(fy[FB-1]);
                    x0_reg <= quo_lon[QBC+FB-1:FB] + QBC'(fx[FB-1]);
                end
                else
                begin
                    y0_reg <= quo_lat[QBR+FB-1:FB];
                    x0_reg <= quo_lon[QBC+FB-1:FB];
                end
                y1_reg       <= quo_lat[QBR+FB-1:FB] + QBR'(fy != '0);
                x1_reg       <= quo_lon[QBC+FB-1:FB] + QBC'(fx != '0);
                rd_reg       <= 2'd0;
                marks_ok_reg <= 1'b1;
            end
            gebs_pkg::S_READ:
                rd_reg <= rd_reg + 2'd1;
            gebs_pkg::S_CHECK:
                if (!marks_ok_reg)
                    status_reg <= gebs_pkg::ST_UNWRITTEN;
                else if (desc_reg.kind == gebs_pkg::KIND_NEAREST)
                    elev_reg <= cell_reg[0];
            gebs_pkg::S_BMUL0:
            begin
                p0_reg <= blend_prod(cell_reg[0], cell_reg[1], fx);
                p1_reg <= blend_prod(cell_reg[2], cell_reg[3], fx);
            end
            gebs_pkg::S_BRND0:
            begin
                r0_reg <= round_blend(cell_reg[0], p0_reg);
                r1_reg <= round_blend(cell_reg[2], p1_reg);
            end
            gebs_pkg::S_BMUL1:
                p0_reg <= blend_prod(r0_reg, r1_reg, fy);
            gebs_pkg::S_BRND1:
                elev_reg <= round_blend(r0_reg, p0_reg);
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/grid_elevation_bilinear_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_elevation_bilinear_sampler: elevation grid with nearest/bilinear lookup
// Path: a write or an error item passes the descriptor queue and the back end's
// push state to the result queue; a query is also mapped by the bit-serial
// coordinate dividers, reads its cells from the one RAM and, if bilinear, goes
// through the blend steps before its result is pushed.
// Throughput: one item at a time in the back end; the front queue holds two.
// Reset: after rst_n the grid's MAX_ROWS*MAX_COLS cells (65536 by default) are
// swept clear, and full stays high until the sweep ends.
// ----------------------------------------------------------------------------
// The front end holds the configuration registers and classifies each item
// (write, immediate result, nearest or bilinear query). A two-entry queue
// carries descriptors to the back end, which owns the grid RAM, the coordinate
// dividers and the blend. A second two-entry queue holds results until popped,
// so the back end keeps working while a result waits.
// ----------------------------------------------------------------------------
module grid_elevation_bilinear_sampler #(
    parameter int MAX_ROWS      = gebs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS      = gebs_pkg::MAX_COLS_DEF,
    parameter int FRACTION_BITS = gebs_pkg::FRACTION_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration write port
    input  wire                                  cfg_write,
    input  wire [gebs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [gebs_pkg::COORD_W-1:0]          cfg_data,
    // item input
    input  wire                                  push,
    output logic                                 full,
    input  wire                                  operation,
    input  wire [1:0]                            mode,
    input  wire signed [gebs_pkg::COORD_W-1:0]   query_lat,
    input  wire signed [gebs_pkg::COORD_W-1:0]   query_lon,
    input  wire [gebs_pkg::CELL_W-1:0]           cell_col,
    input  wire [gebs_pkg::CELL_W-1:0]           cell_row,
    input  wire signed [gebs_pkg::ELEV_W-1:0]    write_value,
    // result output
    output logic                                 empty,
    input  wire                                  pop,
    output logic signed [gebs_pkg::ELEV_W-1:0]   elevation,
    output logic [gebs_pkg::STATUS_W-1:0]        status
);

    localparam int DW = $bits(gebs_pkg::desc_t);
    localparam int RW = gebs_pkg::RESULT_W;

    gebs_pkg::desc_t desc_wr;
    gebs_pkg::desc_t desc_rd;
    logic [DW-1:0]   desc_rd_bits;
    logic            desc_push;
    logic            desc_full;
    logic            desc_pop;
    logic            desc_empty;
    logic            clearing;
    logic            res_push;
    logic            res_full;
    logic [RW-1:0]   res_data;
    logic [RW-1:0]   res_out;

    // Classify items and hold the configuration.
    gebs_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .mode        (mode),
        .query_lat   (query_lat),
        .query_lon   (query_lon),
        .cell_col    (cell_col),
        .cell_row    (cell_row),
        .write_value (write_value),
        .clearing    (clearing),
        .desc_full   (desc_full),
        .desc_push   (desc_push),
        .desc        (desc_wr)
    );

    // Hold classified items until the back end takes them.
    gebs_fifo #(
        .WIDTH (DW)
    ) u_desc_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (desc_push),
        .wdata (desc_wr),
        .full  (desc_full),
        .pop   (desc_pop),
        .rdata (desc_rd_bits),
        .empty (desc_empty)
    );

    assign desc_rd = gebs_pkg::desc_t'(desc_rd_bits);

    // Execute: store cells, map and blend queries.
    gebs_back #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_COLS      (MAX_COLS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_empty (desc_empty),
        .desc_in    (desc_rd),
        .desc_pop   (desc_pop),
        .clearing   (clearing),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    // Hold finished results until popped.
    gebs_fifo #(
        .WIDTH (RW)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign elevation = res_out[gebs_pkg::ELEV_W-1:0];
    assign status    = res_out[RW-1:gebs_pkg::ELEV_W];

endmodule
`default_nettype wire

// ===== test/tb_grid_elevation_bilinear_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_elevation_bilinear_sampler: self-checking bench of the grid sampler
// Feed writes and queries through the push side while the box and grid size
// are changed between phases. An in-bench model of the grid predicts the
// elevation and status of every item. The pop side checks each result in order.
// ----------------------------------------------------------------------------
module tb_grid_elevation_bilinear_sampler;

    localparam int  FRAC       = 16;
    localparam int  GRID_COLS  = 256;
    localparam int  STALL_MAX  = 300000;  // covers the clear sweep after reset
    localparam longint COORD_LIM = 64'sd3019898880;

    typedef struct {
        logic                                op;
        logic [1:0]                          md;
        logic signed [gebs_pkg::COORD_W-1:0] lat;
        logic signed [gebs_pkg::COORD_W-1:0] lon;
        logic [gebs_pkg::CELL_W-1:0]         col;
        logic [gebs_pkg::CELL_W-1:0]         row;
        logic signed [gebs_pkg::ELEV_W-1:0]  val;
    } sample_item_t;

    typedef struct {
        logic signed [gebs_pkg::ELEV_W-1:0] elev;
        logic [gebs_pkg::STATUS_W-1:0]      st;
    } sample_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [gebs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gebs_pkg::COORD_W-1:0] cfg_data = '0;
    logic push = 1'b0;
    logic full;
    logic operation = 1'b0;
    logic [1:0] mode = '0;
    logic signed [gebs_pkg::COORD_W-1:0] query_lat = '0;
    logic signed [gebs_pkg::COORD_W-1:0] query_lon = '0;
    logic [gebs_pkg::CELL_W-1:0] cell_col = '0;
    logic [gebs_pkg::CELL_W-1:0] cell_row = '0;
    logic signed [gebs_pkg::ELEV_W-1:0] write_value = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [gebs_pkg::ELEV_W-1:0] elevation;
    logic [gebs_pkg::STATUS_W-1:0] status;

    grid_elevation_bilinear_sampler u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .operation(operation), .mode(mode),
        .query_lat(query_lat), .query_lon(query_lon),
        .cell_col(cell_col), .cell_row(cell_row), .write_value(write_value),
        .empty(empty), .pop(pop), .elevation(elevation), .status(status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Grid model: box registers as signed values, sizes as raw register bits.
    longint                             box_reg [4];
    int unsigned                        size_reg [2];
    logic signed [gebs_pkg::ELEV_W-1:0] grid_elev [65536];
    bit                                 grid_mark [65536];

    sample_item_t   pending_items [$];
    sample_result_t expected_results [$];
    sample_item_t   cur_item;
    bit             took = 1'b0;
    int             idle_pct = 27;
    int             fail_count = 0;
    int             stall_cycles = 0;

    function automatic int unsigned clamp_size(int unsigned v);
        if (v < 2) return 2;
        if (v > 256) return 256;
        return v;
    endfunction

    // Map one coordinate onto a grid axis; returns 0 when outside the box.
    function automatic bit axis_to_grid(longint v, longint s, longint e, int unsigned n,
                                        output int unsigned q, output int unsigned f);
        longint lo, hi;
        logic [63:0] d, span, num, r;
        lo = (s < e) ? s : e;
        hi = (s < e) ? e : s;
        q = 0;
        f = 0;
        if (v < lo || v > hi) return 1'b0;
        d = (v >= s) ? v - s : s - v;
        span = (e >= s) ? e - s : s - e;
        if (span == 0) return 1'b1;
        num = d * (n - 1);
        r = num % span;
        q = num / span;
        f = (r << FRAC) / span;
        return 1'b1;
    endfunction

    // Weighted mix of two elevations with a rounding half up to a whole elevation (Q32.0).
    function automatic logic signed [gebs_pkg::ELEV_W-1:0] mix_elev(
        logic signed [gebs_pkg::ELEV_W-1:0] a,
        logic signed [gebs_pkg::ELEV_W-1:0] b,
        int unsigned f);
        longint acc;
        acc = longint'(a) * ((64'sd1 << FRAC) - f) + longint'(b) * longint'(f);
        acc = (acc + (64'sd1 << (FRAC - 1))) >>> FRAC;
        return acc[gebs_pkg::ELEV_W-1:0];
    endfunction

    // Apply one item to the grid model and return the result it must produce.
    function automatic sample_result_t sample_grid(sample_item_t it);
        sample_result_t res;
        int unsigned rows, cols, qy, fy, qx, fx, y, x, y1, x1;
        bit ok_lat, ok_lon;
        logic [15:0] i00, i01, i10, i11;
        logic signed [gebs_pkg::ELEV_W-1:0] r0, r1;
        rows = clamp_size(size_reg[0]);
        cols = clamp_size(size_reg[1]);
        res.elev = '0;
        res.st = gebs_pkg::ST_OK;
        if (it.op == gebs_pkg::OP_WRITE)
        begin
            if (it.col >= cols || it.row >= rows) res.st = gebs_pkg::ST_BAD_INDEX;
            else
            begin
                grid_elev[{it.row, it.col}] = it.val;
                grid_mark[{it.row, it.col}] = 1'b1;
            end
            return res;
        end
        ok_lat = axis_to_grid(longint'(it.lat), box_reg[0], box_reg[2], rows, qy, fy);
        ok_lon = axis_to_grid(longint'(it.lon), box_reg[1], box_reg[3], cols, qx, fx);
        if (!ok_lat || !ok_lon) res.st = gebs_pkg::ST_OUT_OF_BOX;
        else if (it.md == gebs_pkg::MODE_NEAREST)
        begin
            y = qy + ((fy >= (1 << (FRAC - 1))) ? 1 : 0);
            x = qx + ((fx >= (1 << (FRAC - 1))) ? 1 : 0);
            i00 = 16'(y * GRID_COLS + x);
            if (!grid_mark[i00]) res.st = gebs_pkg::ST_UNWRITTEN;
            else res.elev = grid_elev[i00];
        end
        else if (it.md == gebs_pkg::MODE_BILINEAR)
        begin
            y1 = qy + ((fy != 0) ? 1 : 0);
            x1 = qx + ((fx != 0) ? 1 : 0);
            i00 = 16'(qy * GRID_COLS + qx);
            i01 = 16'(qy * GRID_COLS + x1);
            i10 = 16'(y1 * GRID_COLS + qx);
            i11 = 16'(y1 * GRID_COLS + x1);
            if (!grid_mark[i00] || !grid_mark[i01] || !grid_mark[i10] || !grid_mark[i11])
                res.st = gebs_pkg::ST_UNWRITTEN;
            else
            begin
                r0 = mix_elev(grid_elev[i00], grid_elev[i01], fx);
                r1 = mix_elev(grid_elev[i10], grid_elev[i11], fx);
                res.elev = mix_elev(r0, r1, fy);
            end
        end
        else res.st = gebs_pkg::ST_UNSUPPORTED;
        return res;
    endfunction

    // Accept side: predict each accepted item; check each popped result.
    always @(posedge clk)
    begin
        sample_result_t exp_res;
        if (rst_n && push && !full)
        begin
            expected_results.push_back(sample_grid(cur_item));
            took = 1'b1;
        end
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: elevation %0d status %0d",
                       elevation, status);
                fail_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (elevation !== exp_res.elev)
                begin
                    $error("elevation: expected %0d, got %0d", exp_res.elev, elevation);
                    fail_count++;
                end
                if (status !== exp_res.st)
                begin
                    $error("status: expected %0d, got %0d", exp_res.st, status);
                    fail_count++;
                end
            end
        end
        // Watchdog: count cycles where neither side moves an item.
        if ((push && !full) || (pop && !empty)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Driver: hold the item until taken, then advance or idle at random.
    always @(negedge clk)
    begin
        if (!push || took)
        begin
            took = 1'b0;
            if (rst_n && pending_items.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                cur_item = pending_items.pop_front();
                push <= 1'b1;
                operation <= cur_item.op;
                mode <= cur_item.md;
                query_lat <= cur_item.lat;
                query_lon <= cur_item.lon;
                cell_col <= cur_item.col;
                cell_row <= cur_item.row;
                write_value <= cur_item.val;
            end
            else push <= 1'b0;
        end
        pop <= ($urandom_range(99) >= idle_pct);
    end

    function automatic longint rand_coord();
        longint r;
        r = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF);
        return (r % (2 * COORD_LIM + 1)) - COORD_LIM;
    endfunction

    // Point at grid coordinate t (FRAC fraction bits) along an axis of the box.
    function automatic longint axis_point(longint s, longint e, int unsigned n, longint t);
        return s + ((e - s) * t) / (longint'(n - 1) << FRAC);
    endfunction

    task automatic add_write(int r, int c, logic signed [gebs_pkg::ELEV_W-1:0] v);
        sample_item_t it;
        it = '{gebs_pkg::OP_WRITE, 2'($urandom), gebs_pkg::COORD_W'(rand_coord()),
               gebs_pkg::COORD_W'(rand_coord()), gebs_pkg::CELL_W'(c),
               gebs_pkg::CELL_W'(r), v};
        pending_items.push_back(it);
    endtask

    task automatic add_query(logic [1:0] md, longint lat, longint lon);
        sample_item_t it;
        it = '{gebs_pkg::OP_QUERY, md, gebs_pkg::COORD_W'(lat), gebs_pkg::COORD_W'(lon),
               gebs_pkg::CELL_W'($urandom), gebs_pkg::CELL_W'($urandom),
               gebs_pkg::ELEV_W'($urandom)};
        pending_items.push_back(it);
    endtask

    task automatic write_reg(logic [gebs_pkg::CFG_IDX_W-1:0] idx, longint v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= gebs_pkg::COORD_W'(v);
        if (idx < gebs_pkg::REG_ROWS_USED)
            box_reg[idx] = longint'(signed'(gebs_pkg::COORD_W'(v)));
        else size_reg[idx - gebs_pkg::REG_ROWS_USED] = v & 9'h1FF;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Drain: wait for every item to go and every result to come back.
    task automatic drain();
        while (pending_items.size() != 0 || push || expected_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // One random phase: write a small corner patch, then mostly queries into it.
    task automatic run_phase(int count);
        int unsigned rows, cols, rr, cc;
        longint t_lat, t_lon, lat, lon;
        int sel;
        rows = clamp_size(size_reg[0]);
        cols = clamp_size(size_reg[1]);
        rr = (rows < 5) ? rows : 5;
        cc = (cols < 5) ? cols : 5;
        for (int r = 0; r < rr; r++)
            for (int c = 0; c < cc; c++)
                if ($urandom_range(99) < 88) add_write(r, c, gebs_pkg::ELEV_W'($urandom));
        for (int k = 0; k < count; k++)
        begin
            sel = $urandom_range(99);
            t_lat = $urandom_range(0, (rr - 1) << FRAC);
            t_lon = $urandom_range(0, (cc - 1) << FRAC);
            if (sel < 12) t_lat = t_lat & ~64'hFFFF;  // land on a grid line
            lat = axis_point(box_reg[0], box_reg[2], rows, t_lat);
            lon = axis_point(box_reg[1], box_reg[3], cols, t_lon);
            if (sel < 70)
                add_query(($urandom_range(99) < 55) ? gebs_pkg::MODE_BILINEAR
                                                    : gebs_pkg::MODE_NEAREST,
                          lat, lon);
            else if (sel < 78) add_query(2'($urandom), rand_coord(), rand_coord());
            else if (sel < 86) add_query(2'($urandom_range(2, 3)), lat, lon);
            else add_write($urandom_range(0, 255), $urandom_range(0, 255),
                           gebs_pkg::ELEV_W'($urandom));
        end
        drain();
    endtask

    initial
    begin
        box_reg = '{0, 0, 0, 0};
        size_reg = '{256, 256};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: degenerate box at reset, unwritten cell, extremes, modes.
        add_query(gebs_pkg::MODE_NEAREST, 0, 0);
        add_query(gebs_pkg::MODE_BILINEAR, 0, 0);
        add_write(0, 0, 32'sh7FFF_FFFF);
        add_write(255, 255, 32'sh8000_0000);
        add_query(gebs_pkg::MODE_NEAREST, 0, 0);
        add_query(gebs_pkg::MODE_BILINEAR, 0, 0);
        add_query(2'd2, 0, 0);
        add_query(2'd3, 0, 0);
        add_query(gebs_pkg::MODE_NEAREST, 1, 0);
        add_query(gebs_pkg::MODE_BILINEAR, 0, -1);
        add_query(2'd2, COORD_LIM, -COORD_LIM);
        drain();

        // Full-range box, reversed along latitude, tiny grid.
        write_reg(gebs_pkg::REG_LAT_START, COORD_LIM);
        write_reg(gebs_pkg::REG_LAT_END, -COORD_LIM);
        write_reg(gebs_pkg::REG_LON_START, -COORD_LIM);
        write_reg(gebs_pkg::REG_LON_END, COORD_LIM);
        write_reg(gebs_pkg::REG_ROWS_USED, 2);
        write_reg(gebs_pkg::REG_COLS_USED, 2);
        add_write(0, 0, 32'sh8000_0000);
        add_write(0, 1, 32'sh7FFF_FFFF);
        add_write(1, 0, 32'sh7FFF_FFFF);
        add_write(1, 1, 32'sh8000_0000);
        add_write(2, 0, 32'sd5);
        add_write(0, 2, 32'sd5);
        add_query(gebs_pkg::MODE_BILINEAR, COORD_LIM, -COORD_LIM);
        add_query(gebs_pkg::MODE_BILINEAR, -COORD_LIM, COORD_LIM);
        add_query(gebs_pkg::MODE_BILINEAR, 0, 0);
        add_query(gebs_pkg::MODE_NEAREST, 0, 0);
        add_query(gebs_pkg::MODE_NEAREST, -COORD_LIM, -COORD_LIM);
        drain();

        // Random phases; the first has no idling at all.
        for (int p = 0; p < 13; p++)
        begin
            idle_pct = (p == 0) ? 0 : 27;
            case (p % 4)
                0:
                begin
                    write_reg(gebs_pkg::REG_ROWS_USED, 0);
                    write_reg(gebs_pkg::REG_COLS_USED, 511);
                end
                1:
                begin
                    write_reg(gebs_pkg::REG_ROWS_USED, 256);
                    write_reg(gebs_pkg::REG_COLS_USED, 1);
                end
                default:
                begin
                    write_reg(gebs_pkg::REG_ROWS_USED, $urandom_range(2, 9));
                    write_reg(gebs_pkg::REG_COLS_USED, $urandom_range(2, 9));
                end
            endcase
            for (int i = 0; i < 4; i++)
                write_reg(3'(i), (p == 5 && i < 2) ? 0 : rand_coord());
            if (p == 5)
            begin
                write_reg(gebs_pkg::REG_LAT_END, 0);  // degenerate latitude span
                write_reg(gebs_pkg::REG_LON_END, 0);
            end
            run_phase(90);
        end

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
